FILE: hw/rtl/rpn_pkg.sv
// shared types and constants for the rpn stack calculator
package rpn_pkg;

   localparam int DATA_W = 32;
   localparam int PUSH_W = 31;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 3'd0,
      CMD_ADD       = 3'd1,
      CMD_SUB       = 3'd2,
      CMD_MUL       = 3'd3,
      CMD_DIV       = 3'd4,
      CMD_PRINT_TOP = 3'd5,
      CMD_PRINT_ALL = 3'd6,
      CMD_CLEAR     = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_DIVZ  = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/rpn_stack_mem.sv
// stack storage: one write port, one read port with registered read data
module rpn_stack_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [rpn_pkg::DATA_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [rpn_pkg::DATA_W-1:0]  rd_data
);

   logic [rpn_pkg::DATA_W-1:0] mem [DEPTH];
   logic [rpn_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rpn_divider.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module rpn_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpn_pkg::DATA_W-1:0]  dividend,
   input  logic [rpn_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [rpn_pkg::DATA_W-1:0]  quotient
);

   localparam int W  = rpn_pkg::DATA_W;
   localparam int SW = $clog2(W);

   logic [W-1:0]  quo_ff;
   logic [W-1:0]  rem_ff;
   logic [W-1:0]  dsr_ff;
   logic          neg_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [SW-1:0] step_ff;
   logic [W:0]    trial;
   logic [W-1:0]  dvd_mag;
   logic [W-1:0]  dsr_mag;

   assign dvd_mag = dividend[W-1] ? W'(-dividend) : dividend;
   assign dsr_mag = divisor[W-1] ? W'(-divisor) : divisor;
   assign trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dvd_mag;
            rem_ff  <= '0;
            dsr_ff  <= dsr_mag;
            neg_ff  <= dividend[W-1] ^ divisor[W-1];
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            // restoring step: borrow means the trial subtract failed
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[W-2:0], quo_ff[W-1]};
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            step_ff <= step_ff + SW'(1);
            if (step_ff == SW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? W'(-quo_ff) : quo_ff;

endmodule

FILE: hw/rtl/rpn_stack_calculator.sv
// top level of the rpn stack calculator: token sequencer around the stack memory
//
//  channel | direction | tdata               | tuser        | tlast
//  req_    | in        | push_value [30:0]   | cmd [2:0]    | -
//  rsp_    | out       | result_value [31:0] | status [1:0] | last_of_run
//
// push and clear complete on acceptance; add, subtract and multiply step through
// two reads of the single memory read port, compute and write back.
// divide waits for the one-bit-per-cycle divider before write back; divide by zero ends in the error state.
// print top and underflow or overflow errors give one result, print all one result per value.
// reset is synchronous and empties the stack; no clearing pass is needed.
// a stalled result holds the sequencer; tokens are taken only between items.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // push_value [30:0], zero [31]
   input  logic [rpn_pkg::CMD_W-1:0]           req_tuser,   // cmd [2:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [rpn_pkg::DATA_W-1:0]   rsp_tdata,   // result_value [31:0]
   output logic [rpn_pkg::STAT_W-1:0]          rsp_tuser,   // status [1:0]
   output logic                                rsp_tlast
);

   localparam int W      = rpn_pkg::DATA_W;
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_A,
      S_EXEC,
      S_DIV,
      S_WB,
      S_ERR,
      S_OUT
   } state_type;

   state_type            state_ff;
   rpn_pkg::cmd_type     cmd_ff;
   rpn_pkg::status_type  err_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [ADDR_W-1:0]    idx_ff;
   logic                 single_ff;
   logic [W-1:0]         b_ff;
   logic [W-1:0]         res_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [W-1:0]         rsp_data_ff;
   rpn_pkg::status_type  rsp_status_ff;
   logic                 rsp_last_ff;

   rpn_pkg::cmd_type     req_cmd;
   logic                 accept;
   logic                 out_free;
   logic                 full;
   logic                 two_or_more;
   logic                 empty;
   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     cnt_m2;
   logic                 out_last;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [W-1:0]         mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [W-1:0]         mem_rdata;

   logic                 div_start;
   logic                 div_done;
   logic [W-1:0]         div_quot;

   assign req_cmd     = rpn_pkg::cmd_type'(req_tuser);
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign full        = (count_ff == CNT_W'(STACK_DEPTH));
   assign two_or_more = (count_ff >= CNT_W'(2));
   assign empty       = (count_ff == '0);
   assign cnt_m1      = count_ff - CNT_W'(1);
   assign cnt_m2      = count_ff - CNT_W'(2);
   assign out_last    = single_ff || (idx_ff == '0);
   assign div_start   = (state_ff == S_EXEC) && (cmd_ff == rpn_pkg::CMD_DIV) && (b_ff != '0);

   // result register: cleared when taken, loaded when a result is ready
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (((state_ff == S_ERR) || (state_ff == S_OUT)) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // memory port control; writes and reads never fall in the same cycle
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = {1'b0, req_tdata[rpn_pkg::PUSH_W-1:0]};
      mem_re    = 1'b0;
      mem_raddr = cnt_m1[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  rpn_pkg::CMD_PUSH: begin
                     mem_we = !full;
                  end
                  rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                  rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                     mem_re = two_or_more;
                  end
                  rpn_pkg::CMD_PRINT_TOP, rpn_pkg::CMD_PRINT_ALL: begin
                     mem_re = !empty;
                  end
                  default: begin
                     mem_re = 1'b0;
                  end
               endcase
            end
         end
         S_RD_A: begin
            mem_re    = 1'b1;
            mem_raddr = cnt_m2[ADDR_W-1:0];
         end
         S_WB: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[ADDR_W-1:0];
            mem_wdata = res_ff;
         end
         S_OUT: begin
            // fetch the next lower entry while this one goes out
            mem_re    = out_free && !out_last;
            mem_raddr = idx_ff - ADDR_W'(1);
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_cmd;
                  case (req_cmd)
                     rpn_pkg::CMD_PUSH: begin
                        if (full) begin
                           err_ff   <= rpn_pkg::STAT_OVER;
                           state_ff <= S_ERR;
                        end else begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                     rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                        if (two_or_more) begin
                           state_ff <= S_RD_A;
                        end else begin
                           err_ff   <= rpn_pkg::STAT_UNDER;
                           state_ff <= S_ERR;
                        end
                     end
                     rpn_pkg::CMD_PRINT_TOP: begin
                        if (empty) begin
                           err_ff   <= rpn_pkg::STAT_UNDER;
                           state_ff <= S_ERR;
                        end else begin
                           idx_ff    <= cnt_m1[ADDR_W-1:0];
                           single_ff <= 1'b1;
                           state_ff  <= S_OUT;
                        end
                     end
                     rpn_pkg::CMD_PRINT_ALL: begin
                        if (!empty) begin
                           idx_ff    <= cnt_m1[ADDR_W-1:0];
                           single_ff <= 1'b0;
                           state_ff  <= S_OUT;
                        end
                     end
                     rpn_pkg::CMD_CLEAR: begin
                        count_ff <= '0;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_RD_A: begin
               b_ff     <= mem_rdata;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               // read data now holds the left operand
               case (cmd_ff)
                  rpn_pkg::CMD_ADD: begin
                     res_ff   <= mem_rdata + b_ff;
                     state_ff <= S_WB;
                  end
                  rpn_pkg::CMD_SUB: begin
                     res_ff   <= mem_rdata - b_ff;
                     state_ff <= S_WB;
                  end
                  rpn_pkg::CMD_MUL: begin
                     res_ff   <= W'(mem_rdata * b_ff);
                     state_ff <= S_WB;
                  end
                  rpn_pkg::CMD_DIV: begin
                     if (b_ff == '0) begin
                        err_ff   <= rpn_pkg::STAT_DIVZ;
                        state_ff <= S_ERR;
                     end else begin
                        state_ff <= S_DIV;
                     end
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
            S_DIV: begin
               if (div_done) begin
                  res_ff   <= div_quot;
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               count_ff <= cnt_m1;
               state_ff <= S_IDLE;
            end
            S_ERR: begin
               if (out_free) begin
                  rsp_data_ff   <= '0;
                  rsp_status_ff <= err_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_data_ff   <= mem_rdata;
                  rsp_status_ff <= rpn_pkg::STAT_OK;
                  rsp_last_ff   <= out_last;
                  if (out_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff - ADDR_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   rpn_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mem_rdata),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory read and write in the same cycle");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_wb_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("write back did not pop one entry");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != rpn_pkg::STAT_OK)) |-> rsp_last_ff)
      else $error("error result not marked last");

endmodule
